[design/ajs_pkg.sv]
package ajs_pkg;

    // joint count and field widths
    localparam int N_JOINT   = 6;
    localparam int IDX_W     = 3;
    localparam int ANGLE_W   = 15;
    localparam int LEVEL_W   = 12;
    localparam int FILT_W    = 24;
    localparam int WEIGHT_W  = 9;
    localparam int RATIO_W   = 8;
    localparam int PULSE_W   = 16;
    localparam int DUTY_W    = 4;
    localparam int ADDR_W    = 3;
    localparam int SPEED_W   = 8;
    localparam int IN_DATA_W = 104;
    localparam int OUT_DATA_W = 32;

    // configuration register indexes
    localparam logic [2:0] REG_WEIGHT      = 3'd0;
    localparam logic [2:0] REG_RATIO_FIRST = 3'd1;

    // arithmetic constants
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE    = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 9'd205;
    localparam logic [FILT_W-1:0]   WRIST_LIMIT   = 24'd1474560;
    localparam logic [24:0]         Q1_SAT        = 25'd589824;
    localparam logic [20:0]         RECIP9        = 21'd1864135;
    localparam logic [3:0]          NINE          = 4'd9;
    localparam logic [PULSE_W-1:0]  PULSE_MAX     = 16'hFFFF;
    localparam logic [SPEED_W-1:0]  SPEED_NORM    = 8'd100;
    localparam logic [SPEED_W-1:0]  SPEED_FAST    = 8'd150;
    localparam logic [DUTY_W-1:0]   DUTY_BASE     = 4'd3;
    localparam logic [ADDR_W-1:0]   SERVO_ADDR    = 3'd0;

    // joint slots of pitch, roll, yaw and the wrist, and the last joint slot
    localparam logic [IDX_W-1:0] IDX_PITCH = 3'd0;
    localparam logic [IDX_W-1:0] IDX_ROLL  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_YAW   = 3'd2;
    localparam logic [IDX_W-1:0] IDX_WRIST = 3'd5;
    localparam logic [IDX_W-1:0] IDX_LAST  = 3'd5;

    // motor address of each joint slot
    function automatic logic [ADDR_W-1:0] joint_addr(input logic [IDX_W-1:0] idx);
        logic [ADDR_W-1:0] a;
        case (idx)
            3'd0:    a = 3'd1;
            3'd1:    a = 3'd6;
            3'd2:    a = 3'd2;
            3'd3:    a = 3'd3;
            3'd4:    a = 3'd4;
            default: a = 3'd5;
        endcase
        return a;
    endfunction

    // gear ratio after reset
    function automatic logic [RATIO_W-1:0] reset_ratio(input logic [IDX_W-1:0] idx);
        logic [RATIO_W-1:0] r;
        case (idx)
            3'd0:    r = 8'd30;
            3'd1:    r = 8'd20;
            3'd4:    r = 8'd1;
            default: r = 8'd10;
        endcase
        return r;
    endfunction

    // controller to datapath commands
    typedef struct packed {
        logic             load_in;
        logic             mul_w;
        logic             filt;
        logic             mul_r;
        logic             scale;
        logic             recip;
        logic             emit_joint;
        logic             emit_servo;
        logic [IDX_W-1:0] idx;
    } ajs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } ajs_status_t;

endpackage

[design/ajs_ctrl.sv]
module ajs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ajs_pkg::ajs_status_t status,
    output ajs_pkg::ajs_cmd_t    cmd
);
    import ajs_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MULW  = 8'b0000_0010,
        ST_FILT  = 8'b0000_0100,
        ST_MULR  = 8'b0000_1000,
        ST_SCALE = 8'b0001_0000,
        ST_RECIP = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_SERVO = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    // state and joint counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.idx        = idx_reg;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    idx_next   = '0;
                    state_next = ST_MULW;
                end
            end
            ST_MULW: begin
                cmd.mul_w  = 1'b1;
                state_next = ST_FILT;
            end
            ST_FILT: begin
                cmd.filt   = 1'b1;
                state_next = ST_MULR;
            end
            ST_MULR: begin
                cmd.mul_r  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.recip  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_joint = 1'b1;
                    if (idx_reg == IDX_LAST) begin
                        state_next = ST_SERVO;
                    end else begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_MULW;
                    end
                end
            end
            ST_SERVO: begin
                if (status.out_free) begin
                    cmd.emit_servo = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/ajs_dp.sv]
module ajs_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [ajs_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              cfg_wr_en,
    input  logic [2:0]                        cfg_addr,
    input  logic [ajs_pkg::WEIGHT_W-1:0]      cfg_wr_data,
    input  ajs_pkg::ajs_cmd_t                 cmd,
    output ajs_pkg::ajs_status_t              status,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ajs_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast
);
    import ajs_pkg::*;

    // configuration registers
    logic [WEIGHT_W-1:0] weight_reg;
    logic [RATIO_W-1:0]  ratio_reg [N_JOINT];

    // captured word and joint state
    logic signed [ANGLE_W-1:0] angle_reg [N_JOINT];
    logic [LEVEL_W-1:0]        level_reg;
    logic signed [FILT_W-1:0]  filt_reg [N_JOINT];

    // per-joint working registers
    logic signed [33:0]        p1_reg;
    logic signed [FILT_W-1:0]  f_reg;
    logic [31:0]               p2_reg;
    logic [19:0]               q1_reg;
    logic                      sat_reg;
    logic [PULSE_W-1:0]        est_reg;

    // output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    logic [WEIGHT_W-1:0]      w_eff;
    logic [WEIGHT_W-1:0]      w_rest;
    logic signed [24:0]       x_term;
    logic signed [26:0]       f_sum;
    logic signed [FILT_W-1:0] f_new;
    logic signed [24:0]       f_wide;
    logic [FILT_W-1:0]        mag_raw;
    logic [FILT_W-1:0]        mag;
    logic [34:0]              p2x5;
    logic [24:0]              q1_full;
    logic [40:0]              recip_prod;
    logic [20:0]              est_x9;
    logic [20:0]              rem;
    logic [PULSE_W-1:0]       pulse;
    logic                     f_pos;
    logic                     dir;
    logic [15:0]              level_x10;
    logic [DUTY_W-1:0]        duty;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
            for (int k = 0; k < N_JOINT; k++) begin
                ratio_reg[k] <= reset_ratio(IDX_W'(k));
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_WEIGHT) begin
                weight_reg <= cfg_wr_data;
            end
            for (int k = 0; k < N_JOINT; k++) begin
                if (cfg_addr == REG_RATIO_FIRST + 3'(k)) begin
                    ratio_reg[k] <= cfg_wr_data[RATIO_W-1:0];
                end
            end
        end
    end

    // filter weight, saturated to one
    assign w_eff  = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign w_rest = WEIGHT_ONE - w_eff;

    // new filter value: x*(256-w) + floor(f_old*w/256), clamped to 24 bits
    assign x_term = 25'(angle_reg[cmd.idx]) * 25'($signed({1'b0, w_rest}));
    assign f_sum  = 27'(x_term) + 27'($signed(p1_reg[33:8]));
    always_comb begin
        if (f_sum > 27'sd8388607) begin
            f_new = 24'sh7FFFFF;
        end else if (f_sum < -27'sd8388608) begin
            f_new = 24'sh800000;
        end else begin
            f_new = f_sum[FILT_W-1:0];
        end
    end

    // magnitude, wrist limited
    assign f_wide  = 25'(f_reg);
    assign mag_raw = f_reg[FILT_W-1] ? FILT_W'(-f_wide) : FILT_W'(f_wide);
    assign mag     = (cmd.idx == IDX_WRIST && mag_raw > WRIST_LIMIT) ? WRIST_LIMIT : mag_raw;

    // scale by 5/1024, then divide by 9 through the reciprocal
    assign p2x5       = {1'b0, p2_reg, 2'b00} + 35'(p2_reg);
    assign q1_full    = p2x5[34:10];
    assign recip_prod = 41'(q1_reg) * 41'(RECIP9);
    assign est_x9     = {2'b00, est_reg, 3'b000} + 21'(est_reg);
    assign rem        = {1'b0, q1_reg} - est_x9;
    assign pulse      = sat_reg ? PULSE_MAX :
                        (rem >= 21'(NINE)) ? est_reg + 16'd1 : est_reg;

    // direction rule per joint
    assign f_pos = !f_reg[FILT_W-1] && (f_reg != '0);
    always_comb begin
        if (cmd.idx == IDX_PITCH) begin
            dir = 1'b1;
        end else if (cmd.idx == IDX_YAW) begin
            dir = f_pos;
        end else begin
            dir = !f_pos;
        end
    end

    // claw duty: floor(level*10/4096) + 3
    assign level_x10 = {1'b0, level_reg, 3'b000} + {3'b000, level_reg, 1'b0};
    assign duty      = level_x10[15:12] + DUTY_BASE;

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N_JOINT; k++) begin
                filt_reg[k] <= '0;
            end
        end else if (cmd.filt) begin
            filt_reg[cmd.idx] <= f_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            for (int k = 0; k < N_JOINT; k++) begin
                angle_reg[k] <= s_tdata[k*ANGLE_W +: ANGLE_W];
            end
            level_reg <= s_tdata[N_JOINT*ANGLE_W +: LEVEL_W];
        end
        if (cmd.mul_w) begin
            p1_reg <= 34'(filt_reg[cmd.idx]) * 34'($signed({1'b0, w_eff}));
        end
        if (cmd.filt) begin
            f_reg <= f_new;
        end
        if (cmd.mul_r) begin
            p2_reg <= 32'(mag) * 32'(ratio_reg[cmd.idx]);
        end
        if (cmd.scale) begin
            sat_reg <= (q1_full >= Q1_SAT);
            q1_reg  <= q1_full[19:0];
        end
        if (cmd.recip) begin
            est_reg <= recip_prod[39:24];
        end
    end

    // output register: a word waits here while the next is worked on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_joint || cmd.emit_servo) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_joint) begin
            out_data_reg <= {{DUTY_W{1'b0}}, pulse,
                             (cmd.idx == IDX_ROLL) ? SPEED_FAST : SPEED_NORM,
                             dir, joint_addr(cmd.idx)};
            out_last_reg <= 1'b0;
        end else if (cmd.emit_servo) begin
            out_data_reg <= {duty, {PULSE_W{1'b0}}, {SPEED_W{1'b0}}, 1'b0, SERVO_ADDR};
            out_last_reg <= 1'b1;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tlast         = out_last_reg;

endmodule

[design/arm_joint_smoothing_stepper_cmd_top.sv]
// Channel   Dir  Handshake           Payload
// s_        in   s_tvalid/s_tready   s_tdata: six 15-bit angles, claw level
// m_        out  m_tvalid/m_tready   m_tdata: command fields, m_tlast: last
// cfg_      in   cfg_wr_en           cfg_addr, cfg_wr_data (no read-back)
//
// A packet is accepted, then each joint takes the weight, filter, ratio, scale,
// reciprocal and emit steps on the shared filter and pulse multipliers; the claw
// word goes last. A new packet is taken only once the claw word is registered.
// Reset (aresetn low, synchronous) clears the filter state and loads the
// register defaults. Output stalls hold the sequencer in either emit step.
module arm_joint_smoothing_stepper_cmd_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [14:0] upper_pitch, [29:15] upper_roll, [44:30] upper_yaw,
    // [59:45] fore_roll, [74:60] fore_yaw, [89:75] hand_roll, [101:90] claw_level
    input  logic [ajs_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] joint_address, [3] direction, [11:4] speed, [27:12] pulse_count,
    // [31:28] servo_duty
    output logic [ajs_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [2:0]                       cfg_addr,
    input  logic [ajs_pkg::WEIGHT_W-1:0]     cfg_wr_data
);
    import ajs_pkg::*;

    ajs_cmd_t    cmd;
    ajs_status_t status;

    ajs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ajs_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

[design/ajs_checker.sv]
module ajs_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed under stall");

    // the claw word carries address zero and only the duty field
    a_servo_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[27:0] == 28'd0)
        else $error("claw word has stepper fields set");

    // stepper words carry a motor address and one of the two speeds
    a_step_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[2:0] != 3'd0 && m_tdata[31:28] == 4'd0 &&
        (m_tdata[11:4] == 8'd100 || m_tdata[11:4] == 8'd150))
        else $error("malformed stepper word");

    // one packet at a time
    a_one_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a packet is in work");

    // reset empties the output
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind arm_joint_smoothing_stepper_cmd_top ajs_port_checker u_ajs_port_checker (.*);

[bench/ajs_checker.sv]
module ajs_checker
    import ajs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_addr,
    input  logic [WEIGHT_W-1:0]   cfg_wr_data,
    output int                    fail_count,
    output int                    due_count
);

    // one command word as it leaves the block
    typedef struct packed {
        logic [ADDR_W-1:0]  joint_address;
        logic               direction;
        logic [SPEED_W-1:0] speed;
        logic [PULSE_W-1:0] pulse_count;
        logic [DUTY_W-1:0]  servo_duty;
        logic               last_result;
    } motor_cmd_t;

    // motor address and default gear ratio per joint slot, slot 0 in the low bits
    localparam logic [N_JOINT*ADDR_W-1:0]  MOTOR_OF =
        {3'd5, 3'd4, 3'd3, 3'd2, 3'd6, 3'd1};
    localparam logic [N_JOINT*RATIO_W-1:0] DEFAULT_RATIOS =
        {8'd10, 8'd1, 8'd10, 8'd10, 8'd20, 8'd30};
    localparam longint FILT_LO = -(longint'(1) << (FILT_W - 1));
    localparam longint FILT_HI = (longint'(1) << (FILT_W - 1)) - 1;

    motor_cmd_t                cmd_q[$];
    logic signed [FILT_W-1:0]  smoothed [N_JOINT];
    logic [WEIGHT_W-1:0]       weight_reg;
    logic [RATIO_W-1:0]        gear_ratio [N_JOINT];
    int                        errs = 0;

    // step pulses for a magnitude in 1/16384 degree, saturating
    function automatic logic [PULSE_W-1:0] pulses_for(input longint mag, input longint r);
        longint n;
        n = mag * r * 5 / 9216;
        return (n > longint'(PULSE_MAX)) ? PULSE_MAX : n[PULSE_W-1:0];
    endfunction

    // run one packet through the smoothing filters and queue its seven words
    task automatic predict_packet(input logic [IN_DATA_W-1:0] pkt);
        longint                    w, x, prev, acc, f, mag;
        logic signed [ANGLE_W-1:0] a;
        motor_cmd_t                c;
        int                        level, duty;
        w = (weight_reg > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight_reg);
        for (int j = 0; j < N_JOINT; j++) begin
            a    = pkt[j*ANGLE_W +: ANGLE_W];
            x    = a;
            prev = smoothed[j];
            acc  = x * (256 - w) * 256 + prev * w;
            f    = acc >>> 8;
            if (f < FILT_LO) f = FILT_LO;
            if (f > FILT_HI) f = FILT_HI;
            smoothed[j] = f[FILT_W-1:0];

            c = '0;
            c.joint_address = MOTOR_OF[j*ADDR_W +: ADDR_W];
            if (j == IDX_PITCH)
                c.direction = 1'b1;
            else if (j == IDX_YAW)
                c.direction = (f > 0);
            else
                c.direction = !(f > 0);
            c.speed = (j == IDX_ROLL) ? SPEED_FAST : SPEED_NORM;
            mag = (f < 0) ? -f : f;
            // wrist travel is limited to +/-90 degrees
            if (j == IDX_WRIST && mag > longint'(WRIST_LIMIT))
                mag = longint'(WRIST_LIMIT);
            c.pulse_count = pulses_for(mag, longint'(gear_ratio[j]));
            cmd_q.push_back(c);
        end
        // claw servo word closes the packet
        level = pkt[N_JOINT*ANGLE_W +: LEVEL_W];
        duty  = level * 10 / 4096 + DUTY_BASE;
        c = '0;
        c.joint_address = SERVO_ADDR;
        c.servo_duty    = duty[DUTY_W-1:0];
        c.last_result   = 1'b1;
        cmd_q.push_back(c);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        motor_cmd_t got, want;
        if (!aresetn) begin
            cmd_q.delete();
            weight_reg = WEIGHT_RESET;
            for (int j = 0; j < N_JOINT; j++) begin
                smoothed[j]   = '0;
                gear_ratio[j] = DEFAULT_RATIOS[j*RATIO_W +: RATIO_W];
            end
        end else begin
            // register writes; indexes past the last ratio are dropped
            if (cfg_wr_en) begin
                if (cfg_addr == REG_WEIGHT)
                    weight_reg = cfg_wr_data;
                else if (cfg_addr >= REG_RATIO_FIRST && cfg_addr < REG_RATIO_FIRST + N_JOINT)
                    gear_ratio[cfg_addr - REG_RATIO_FIRST] = cfg_wr_data[RATIO_W-1:0];
            end

            // result side: compare against the oldest queued word
            if (m_tvalid && m_tready) begin
                got.joint_address = m_tdata[2:0];
                got.direction     = m_tdata[3];
                got.speed         = m_tdata[11:4];
                got.pulse_count   = m_tdata[27:12];
                got.servo_duty    = m_tdata[31:28];
                got.last_result   = m_tlast;
                if (cmd_q.size() == 0) begin
                    $error("unexpected result word: data %h, last %b", m_tdata, m_tlast);
                    errs++;
                end else begin
                    want = cmd_q.pop_front();
                    check_field("joint_address", want.joint_address, got.joint_address);
                    check_field("direction", want.direction, got.direction);
                    check_field("speed", want.speed, got.speed);
                    check_field("pulse_count", want.pulse_count, got.pulse_count);
                    check_field("servo_duty", want.servo_duty, got.servo_duty);
                    check_field("last_result", want.last_result, got.last_result);
                end
            end

            // input side
            if (s_tvalid && s_tready)
                predict_packet(s_tdata);
        end
        fail_count <= errs;
        due_count  <= cmd_q.size();
    end

endmodule

[bench/tb.sv]
module tb;
    import ajs_pkg::*;

    localparam logic [2:0] REG_UNUSED    = REG_RATIO_FIRST + 3'(N_JOINT);
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         SETTLE_CYCLES = 60;
    localparam int         RAND_PHASES   = 6;
    localparam int         PHASE_ITEMS   = 55;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_tvalid    = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic                  m_tready    = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [2:0]            cfg_addr    = '0;
    logic [WEIGHT_W-1:0]   cfg_wr_data = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    int                    fail_count;
    int                    due_count;

    // current packet contents and the ratios for the next register load
    logic [ANGLE_W-1:0]    ang [N_JOINT];
    logic [LEVEL_W-1:0]    claw;
    logic [RATIO_W-1:0]    ratio_set [N_JOINT];

    // idle control, percent per word / per cycle
    int                    send_gap_pct = 0;
    int                    stall_pct    = 0;
    int                    stall_left   = 0;
    int                    cycles       = 0;

    arm_joint_smoothing_stepper_cmd_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    ajs_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .fail_count  (fail_count),
        .due_count   (due_count)
    );

    always #5 aclk = ~aclk;

    // runaway guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("arm_joint_smoothing_stepper_cmd_top: mismatch");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
            stall_left = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [IN_DATA_W-1:0] packet_word();
        logic [IN_DATA_W-1:0] w;
        w = '0;
        for (int j = 0; j < N_JOINT; j++)
            w[j*ANGLE_W +: ANGLE_W] = ang[j];
        w[N_JOINT*ANGLE_W +: LEVEL_W] = claw;
        return w;
    endfunction

    function automatic logic [ANGLE_W-1:0] rand_angle();
        int v;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom_range(0, 32767) - 16384;   // whole 15-bit code space
            2, 3:    v = $urandom_range(0, 400) - 200;       // around zero
            default: v = $urandom_range(0, 23040) - 11520;   // rated travel
        endcase
        return v[ANGLE_W-1:0];
    endfunction

    task automatic set_angles(input int v);
        for (int j = 0; j < N_JOINT; j++)
            ang[j] = v[ANGLE_W-1:0];
    endtask

    task automatic set_ratios(input int r);
        for (int j = 0; j < N_JOINT; j++)
            ratio_set[j] = r[RATIO_W-1:0];
    endtask

    // offer one packet word, with an optional gap ahead of it
    task automatic send_packet();
        if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= packet_word();
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold off the sender until every queued command has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
    endtask

    // load weight and all ratios, plus a write to the unused index
    task automatic apply_settings(input int weight);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_WEIGHT;
        cfg_wr_data <= weight[WEIGHT_W-1:0];
        for (int j = 0; j < N_JOINT; j++) begin
            @(posedge aclk);
            cfg_addr    <= REG_RATIO_FIRST + 3'(j);
            cfg_wr_data <= WEIGHT_W'(ratio_set[j]);
        end
        @(posedge aclk);
        cfg_addr    <= REG_UNUSED;
        cfg_wr_data <= WEIGHT_W'($urandom_range(0, 511));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int weight;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        send_gap_pct = 20;
        stall_pct    = 10;

        // default settings: zero, rated ends, widest codes, duty step edges
        set_angles(0);       claw = 12'd0;    send_packet();
        set_angles(11520);   claw = 12'd4095; send_packet();
        set_angles(-11520);  claw = 12'd2048; send_packet();
        set_angles(16383);   claw = 12'd409;  send_packet();
        set_angles(-16384);  claw = 12'd410;  send_packet();

        // no smoothing, top ratios: saturated counts and wrist clamp
        drain_results();
        set_ratios(255);
        apply_settings(0);
        set_angles(11520);   claw = 12'd1;    send_packet();
        set_angles(1);       claw = 12'd819;  send_packet();
        set_angles(-1);      claw = 12'd820;  send_packet();
        set_angles(0);       claw = 12'd3686; send_packet();
        for (int j = 0; j < N_JOINT; j++)
            ang[j] = (j % 2) ? 15'(-7000) : 15'(7000);
        claw = 12'd3687;
        send_packet();

        // full weight holds the filter; zero ratios give no pulses
        drain_results();
        set_ratios(0);
        apply_settings(256);
        set_angles(-5000);   claw = 12'd100;  send_packet();
        set_angles(9000);    claw = 12'd3000; send_packet();

        // weight beyond one behaves as one
        drain_results();
        set_ratios(1);
        apply_settings(511);
        set_angles(12345);   claw = 12'd2500; send_packet();
        drain_results();
        apply_settings(257);
        set_angles(-300);    claw = 12'd7;    send_packet();

        // wrist right at, just past and far past the 90 degree limit
        drain_results();
        set_ratios(10);
        apply_settings(0);
        set_angles(5760);    claw = 12'd1000; send_packet();
        set_angles(5761);    claw = 12'd1500; send_packet();
        set_angles(-11520);  claw = 12'd3500; send_packet();

        // random phases, each with its own settings and idle mix
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_results();
            for (int j = 0; j < N_JOINT; j++) begin
                case ($urandom_range(0, 5))
                    0:       ratio_set[j] = 8'd255;
                    1:       ratio_set[j] = 8'd1;
                    default: ratio_set[j] = 8'($urandom_range(0, 255));
                endcase
            end
            case ($urandom_range(0, 5))
                0:       weight = 0;
                1:       weight = 256;
                2:       weight = $urandom_range(257, 511);
                default: weight = $urandom_range(0, 256);
            endcase
            apply_settings(weight);

            if (p == RAND_PHASES - 1) begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end else begin
                case (p % 3)
                    0:       begin send_gap_pct = 0;  stall_pct = 0;  end
                    1:       begin send_gap_pct = 15; stall_pct = 8;  end
                    default: begin send_gap_pct = 40; stall_pct = 25; end
                endcase
            end

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // often keep the target so the filters settle toward it
                if ($urandom_range(0, 9) >= 3) begin
                    for (int j = 0; j < N_JOINT; j++)
                        ang[j] = rand_angle();
                end
                claw = 12'($urandom_range(0, 4095));
                send_packet();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("arm_joint_smoothing_stepper_cmd_top: match");
        else
            $display("arm_joint_smoothing_stepper_cmd_top: mismatch");
        $finish;
    end

endmodule
